>>> src/ecpd_pkg.sv
// Shared types and constants for the escape count palette downsampler.
// Holds field widths, register and command codes, the handshake structs
// and the state enums. It depends on nothing else.
`timescale 1ns / 1ps

package ecpd_pkg;

  localparam int CH_W      = 16;
  localparam int ITER_W    = 32;
  localparam int AA_W      = 4;
  localparam int SHIFT_W   = 5;
  localparam int PLEN_W    = 13;
  localparam int ENTRY_W   = 12;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_AA_FACTOR       = 3'd0;
  localparam cfg_idx_t CFG_ITERATION_LIMIT = 3'd1;
  localparam cfg_idx_t CFG_MAX_ITERATIONS  = 3'd2;
  localparam cfg_idx_t CFG_PALETTE_ROTATE  = 3'd3;
  localparam cfg_idx_t CFG_AUX_SHIFT       = 3'd4;
  localparam cfg_idx_t CFG_PALETTE_LENGTH  = 3'd5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [AA_W-1:0]    AA_FACTOR_RST      = 4'd1;
  localparam logic [ITER_W-1:0]  ITER_LIMIT_RST     = 32'hFFFF_FFFF;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST       = 32'hFFFF_FFFF;
  localparam logic [ITER_W-1:0]  ROTATE_RST         = 32'd0;
  localparam logic [SHIFT_W-1:0] AUX_SHIFT_RST      = 5'd0;
  localparam logic [PLEN_W-1:0]  PALETTE_LENGTH_RST = 13'd4096;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic valid;
    logic add;
    rgb_t color;
  } sample_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_READ,
    S_ACC
  } ctl_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_FIN
  } avg_state_t;

endpackage

>>> src/escape_count_palette_downsampler.sv
// Top level of the escape count palette downsampler.
// Instantiates ecpd_palette, ecpd_rem_unit and ecpd_avg; depends on ecpd_pkg.
//
// Each input item is either a palette write or one supersample iteration
// count. A palette write is taken while idle and leaves the control idle.
// A sample below the iteration limit is rotated, clamped and shifted,
// reduced modulo palette_length by a restoring remainder unit that retires
// one dividend bit per cycle, then looked up in the palette and
// accumulated; no new item is accepted until the accumulator takes it. If
// the remainder lands at or beyond PALETTE_DEPTH a second remainder pass
// reduces it modulo PALETTE_DEPTH. Black samples skip the remainder unit
// and the palette read; a zero palette_length skips the remainder unit and
// reads entry zero. After the last sample of a group the three sums are
// divided by a reciprocal multiply, overlapped with the next item, and the
// pixel waits in an output register until taken. The palette has no
// clearing pass: entries must be written before use.
`timescale 1ns / 1ps

module escape_count_palette_downsampler import ecpd_pkg::*; #(
  parameter int PALETTE_DEPTH = 4096,
  parameter int MAX_AA        = 8,
  parameter int ITER_BITS     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ITER_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [ITER_W-1:0]    in_iter_count,
  input  logic [ENTRY_W-1:0]   in_entry_index,
  input  logic [CH_W-1:0]      in_entry_red,
  input  logic [CH_W-1:0]      in_entry_green,
  input  logic [CH_W-1:0]      in_entry_blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_pixel_red,
  output logic [CH_W-1:0]      out_pixel_green,
  output logic [CH_W-1:0]      out_pixel_blue
);

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int DBITS = $clog2(PALETTE_DEPTH + 1);
  localparam int DSW   = (PLEN_W > DBITS) ? PLEN_W : DBITS;
  localparam int CW    = (ITER_BITS < ITER_W) ? ITER_BITS : ITER_W;
  localparam logic [DSW:0]   DEPTH_V = (DSW + 1)'(PALETTE_DEPTH);
  localparam logic [DSW-1:0] DEPTH_D = DSW'(PALETTE_DEPTH);

  logic [AA_W-1:0]    aa_factor_r;
  logic [ITER_W-1:0]  iteration_limit_r;
  logic [ITER_W-1:0]  max_iter_r;
  logic [ITER_W-1:0]  palette_rotate_r;
  logic [SHIFT_W-1:0] aux_shift_r;
  logic [PLEN_W-1:0]  palette_length_r;

  ctl_state_t    state_r, state_nxt;
  logic          pass2_r, pass2_nxt;
  logic          black_r, black_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] index_r, index_nxt;

  logic [CW:0]       rot_sum;
  logic              rot_carry;
  logic [ITER_W-1:0] rot_v;
  logic [ITER_W-1:0] clamp_top;
  logic [ITER_W-1:0] clamped;
  logic [ITER_W-1:0] shifted;
  logic              is_black;

  logic              rem_start;
  logic [ITER_W-1:0] rem_dividend;
  logic [DSW-1:0]    rem_divisor;
  logic              rem_done;
  logic [DSW-1:0]    rem_value;

  logic    pal_wr_en;
  rgb_t    pal_wr_color;
  logic    pal_rd_en;
  rgb_t    pal_rd_color;
  sample_t sample;
  logic    sample_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aa_factor_r       <= AA_FACTOR_RST;
      iteration_limit_r <= ITER_LIMIT_RST;
      max_iter_r        <= MAX_ITER_RST;
      palette_rotate_r  <= ROTATE_RST;
      aux_shift_r       <= AUX_SHIFT_RST;
      palette_length_r  <= PALETTE_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AA_FACTOR:       aa_factor_r       <= cfg_data[AA_W-1:0];
        CFG_ITERATION_LIMIT: iteration_limit_r <= cfg_data;
        CFG_MAX_ITERATIONS:  max_iter_r        <= cfg_data;
        CFG_PALETTE_ROTATE:  palette_rotate_r  <= cfg_data;
        CFG_AUX_SHIFT:       aux_shift_r       <= cfg_data[SHIFT_W-1:0];
        CFG_PALETTE_LENGTH:  palette_length_r  <= cfg_data[PLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rot_sum   = {1'b0, count_r} + {1'b0, palette_rotate_r[CW-1:0]};
    rot_carry = rot_sum[CW];
    rot_v     = ITER_W'(rot_sum[CW-1:0]);
    clamp_top = (max_iter_r == '0) ? '0 : max_iter_r - 1'b1;
    clamped   = (rot_carry || (rot_v >= max_iter_r)) ? clamp_top : rot_v;
    shifted   = clamped >> aux_shift_r;
    is_black  = ITER_W'(count_r) >= iteration_limit_r;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign pal_wr_en    = in_valid && in_ready && (in_command == CMD_WRITE);
  assign pal_wr_color = '{red: in_entry_red, green: in_entry_green, blue: in_entry_blue};

  always_comb begin
    state_nxt    = state_r;
    pass2_nxt    = pass2_r;
    black_nxt    = black_r;
    count_nxt    = count_r;
    index_nxt    = index_r;
    rem_start    = 1'b0;
    rem_dividend = shifted;
    rem_divisor  = DSW'(palette_length_r);
    pal_rd_en    = 1'b0;
    sample.valid = 1'b0;
    sample.add   = !black_r;
    sample.color = pal_rd_color;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (in_command == CMD_SAMPLE)) begin
          count_nxt = in_iter_count[CW-1:0];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        black_nxt = is_black;
        pass2_nxt = 1'b0;
        if (is_black) begin
          state_nxt = S_ACC;
        end else if (palette_length_r == '0) begin
          index_nxt = '0;
          state_nxt = S_READ;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          if (!pass2_r && ({1'b0, rem_value} >= DEPTH_V)) begin
            rem_start    = 1'b1;
            rem_dividend = ITER_W'(rem_value);
            rem_divisor  = DEPTH_D;
            pass2_nxt    = 1'b1;
          end else begin
            index_nxt = rem_value[AW-1:0];
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        pal_rd_en = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sample.valid = 1'b1;
        if (sample_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass2_r <= 1'b0;
      black_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
      black_r <= black_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    index_r <= index_nxt;
  end

  ecpd_rem_unit #(
    .DVW (ITER_W),
    .DSW (DSW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_value)
  );

  ecpd_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk      (clk),
    .wr_en    (pal_wr_en),
    .wr_index (in_entry_index),
    .wr_color (pal_wr_color),
    .rd_en    (pal_rd_en),
    .rd_addr  (index_r),
    .rd_color (pal_rd_color)
  );

  ecpd_avg #(
    .MAX_AA (MAX_AA)
  ) u_avg (
    .clk          (clk),
    .rst_n        (rst_n),
    .aa_factor    (aa_factor_r),
    .sample       (sample),
    .sample_ready (sample_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_red    (out_pixel_red),
    .pixel_green  (out_pixel_green),
    .pixel_blue   (out_pixel_blue)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_DIV))
    else $error("remainder finished outside the divide state");

  a_read_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_ACC))
    else $error("palette read data not consumed in the next cycle");

endmodule

>>> src/ecpd_rem_unit.sv
// Restoring remainder unit, one dividend bit per cycle.
// Stand-alone; used by the top level for the palette index modulo.
`timescale 1ns / 1ps

module ecpd_rem_unit #(
  parameter int DVW = 32,
  parameter int DSW = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DSW-1:0] remainder
);

  localparam int CNT_W = $clog2(DVW + 1);

  logic [DVW-1:0]   dvd_r, dvd_nxt;
  logic [DSW:0]     rem_r, rem_nxt;
  logic [DSW-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DSW:0]     trial;

  always_comb begin
    trial    = {rem_r[DSW-1:0], dvd_r[DVW-1]};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[DSW-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit restarted while busy");

endmodule

>>> src/ecpd_palette.sv
// Palette memory holding red, green and blue side by side in one word.
// Write port drops addresses beyond the depth; the read data is registered.
// Depends on ecpd_pkg.
`timescale 1ns / 1ps

module ecpd_palette import ecpd_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ENTRY_W-1:0] wr_index,
  input  rgb_t               wr_color,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output rgb_t               rd_color
);

  localparam int EXT_W = AW + ENTRY_W;
  localparam logic [EXT_W-1:0] DEPTH_V = EXT_W'(DEPTH);

  rgb_t             mem [DEPTH];
  rgb_t             rd_color_r;
  logic [EXT_W-1:0] wr_ext;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;

  assign wr_ext  = EXT_W'(wr_index);
  assign wr_ok   = wr_en && (wr_ext < DEPTH_V);
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_color;
    end
    if (rd_en) begin
      rd_color_r <= mem[rd_addr];
    end
  end

  assign rd_color = rd_color_r;

endmodule

>>> src/ecpd_avg.sv
// Box filter: accumulates sample colors, then divides each sum by the
// group size through a reciprocal multiply and holds the pixel in the
// output register. Depends on ecpd_pkg.
`timescale 1ns / 1ps

module ecpd_avg import ecpd_pkg::*; #(
  parameter int MAX_AA = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [AA_W-1:0] aa_factor,
  input  sample_t         sample,
  output logic            sample_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CH_W-1:0] pixel_red,
  output logic [CH_W-1:0] pixel_green,
  output logic [CH_W-1:0] pixel_blue
);

  localparam int NMAX  = MAX_AA * MAX_AA;
  localparam int SW    = CH_W + $clog2(NMAX);
  localparam int CNT_W = $clog2(NMAX + 1);
  localparam int FW    = $clog2(MAX_AA + 1);
  localparam int L     = 2 * $clog2(MAX_AA);
  localparam int K     = SW + L;
  localparam int RW    = K + 1;
  localparam int PW    = SW + RW;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  logic [RW-1:0] recip_tab [2**FW];

  for (genvar g = 0; g < 2**FW; g++) begin : g_recip
    localparam int D = ((g == 0) || (g > MAX_AA)) ? 1 : g * g;
    localparam logic [RW-1:0] R = RW'(((64'd1 << K) + 64'(D) - 64'd1) / 64'(D));
    assign recip_tab[g] = R;
  end

  avg_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SW-1:0]    sum_red_r, sum_red_nxt;
  logic [SW-1:0]    sum_green_r, sum_green_nxt;
  logic [SW-1:0]    sum_blue_r, sum_blue_nxt;
  logic [RW-1:0]    recip_r, recip_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [CH_W-1:0]  red_r, red_nxt;
  logic [CH_W-1:0]  green_r, green_nxt;
  logic [CH_W-1:0]  blue_r, blue_nxt;

  logic [AA_W:0]    aa_ext;
  logic [FW-1:0]    f;
  logic [2*FW-1:0]  f_sq;
  logic [CNT_W-1:0] n;
  logic [CNT_W:0]   cnt_inc;
  logic             group_done;
  logic [SW-1:0]    sel_sum;
  logic [CH_W-1:0]  quot;

  always_comb begin
    aa_ext = {1'b0, aa_factor};
    if (aa_factor == '0) begin
      f = FW'(1);
    end else if (aa_ext > (AA_W + 1)'(MAX_AA)) begin
      f = FW'(MAX_AA);
    end else begin
      f = FW'(aa_factor);
    end
    f_sq       = (2 * FW)'(f) * (2 * FW)'(f);
    n          = CNT_W'(f_sq);
    cnt_inc    = {1'b0, cnt_r} + 1'b1;
    group_done = cnt_inc >= {1'b0, n};
    quot       = prod_r[K +: CH_W];
    case (ch_r)
      CH_RED:   sel_sum = sum_red_r;
      CH_GREEN: sel_sum = sum_green_r;
      default:  sel_sum = sum_blue_r;
    endcase
  end

  assign sample_ready = (state_r == A_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sum_red_nxt   = sum_red_r;
    sum_green_nxt = sum_green_r;
    sum_blue_nxt  = sum_blue_r;
    recip_nxt     = recip_r;
    prod_nxt      = prod_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    case (state_r)
      A_IDLE: begin
        if (sample.valid && sample_ready) begin
          if (sample.add) begin
            sum_red_nxt   = sum_red_r + SW'(sample.color.red);
            sum_green_nxt = sum_green_r + SW'(sample.color.green);
            sum_blue_nxt  = sum_blue_r + SW'(sample.color.blue);
          end
          if (group_done) begin
            cnt_nxt   = '0;
            recip_nxt = recip_tab[f];
            ch_nxt    = CH_RED;
            state_nxt = A_MUL;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
      end
      A_MUL: begin
        prod_nxt = PW'(sel_sum) * PW'(recip_r);
        if (ch_r == CH_GREEN) begin
          red_nxt = quot;
        end
        if (ch_r == CH_BLUE) begin
          green_nxt = quot;
          state_nxt = A_FIN;
        end
        ch_nxt = ch_r + 1'b1;
      end
      A_FIN: begin
        blue_nxt      = quot;
        out_valid_nxt = 1'b1;
        sum_red_nxt   = '0;
        sum_green_nxt = '0;
        sum_blue_nxt  = '0;
        state_nxt     = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= A_IDLE;
      cnt_r       <= '0;
      ch_r        <= CH_RED;
      out_valid_r <= 1'b0;
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      sum_red_r   <= sum_red_nxt;
      sum_green_r <= sum_green_nxt;
      sum_blue_r  <= sum_blue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    recip_r <= recip_nxt;
    prod_r  <= prod_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid   = out_valid_r;
  assign pixel_red   = red_r;
  assign pixel_green = green_r;
  assign pixel_blue  = blue_r;

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_FIN) |-> !out_valid_r)
    else $error("pixel finished while the output register is occupied");

  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} < (CNT_W + 1)'(NMAX))
    else $error("sample count reached the largest group size");

  a_mul_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_MUL) |=> (cnt_r == '0))
    else $error("sample count moved while a pixel was being divided");

endmodule

>>> tb/ecpd_checker.sv
// Scoreboard for the escape count palette downsampler: watches the config,
// input and pixel channels, predicts each pixel and compares it.
// Depends on ecpd_pkg for widths, register and command codes and rgb_t.
`timescale 1ns / 1ps

module ecpd_checker import ecpd_pkg::*; #(
  parameter int PALETTE_DEPTH = 4096,
  parameter int MAX_AA        = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ITER_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic [ITER_W-1:0]    in_iter_count,
  input  logic [ENTRY_W-1:0]   in_entry_index,
  input  logic [CH_W-1:0]      in_entry_red,
  input  logic [CH_W-1:0]      in_entry_green,
  input  logic [CH_W-1:0]      in_entry_blue,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CH_W-1:0]      out_pixel_red,
  input  logic [CH_W-1:0]      out_pixel_green,
  input  logic [CH_W-1:0]      out_pixel_blue,
  output int                   mismatch_count,
  output int                   pixels_owed
);

  logic [CH_W-1:0]    pal_red   [PALETTE_DEPTH];
  logic [CH_W-1:0]    pal_green [PALETTE_DEPTH];
  logic [CH_W-1:0]    pal_blue  [PALETTE_DEPTH];
  rgb_t               pending_pixels[$];
  logic [31:0]        acc_red, acc_green, acc_blue;
  int unsigned        taken;
  int                 mismatches = 0;

  logic [AA_W-1:0]    aa;
  logic [ITER_W-1:0]  limit;
  logic [ITER_W-1:0]  max_iter;
  logic [ITER_W-1:0]  rotate;
  logic [SHIFT_W-1:0] shift;
  logic [PLEN_W-1:0]  plen;

  function automatic int unsigned pixel_group();
    int unsigned f;
    f = aa;
    if (f == 0) f = 1;
    if (f > MAX_AA) f = MAX_AA;
    return f * f;
  endfunction

  function automatic int unsigned palette_slot(logic [ITER_W-1:0] count);
    logic [ITER_W:0]   total;
    logic [ITER_W-1:0] v;
    logic [ITER_W-1:0] ceiling;
    total = {1'b0, count} + {1'b0, rotate};
    v = total[ITER_W-1:0];
    ceiling = (max_iter == '0) ? '0 : max_iter - 1'b1;
    if (total[ITER_W] || v >= max_iter) v = ceiling;
    v = v >> shift;
    if (plen == '0) return 0;
    v = v % ITER_W'(plen);
    return v % PALETTE_DEPTH;
  endfunction

  always @(posedge clk) begin
    rgb_t        want;
    rgb_t        got;
    int unsigned slot;
    int unsigned n;
    if (!rst_n) begin
      pending_pixels.delete();
      taken = 0;
      acc_red = '0;
      acc_green = '0;
      acc_blue = '0;
      aa = AA_FACTOR_RST;
      limit = ITER_LIMIT_RST;
      max_iter = MAX_ITER_RST;
      rotate = ROTATE_RST;
      shift = AUX_SHIFT_RST;
      plen = PALETTE_LENGTH_RST;
    end else begin
      if (out_valid && out_ready) begin
        got.red = out_pixel_red;
        got.green = out_pixel_green;
        got.blue = out_pixel_blue;
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (got.red !== want.red) begin
            $error("pixel_red: expected %0d, got %0d", want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $error("pixel_green: expected %0d, got %0d", want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $error("pixel_blue: expected %0d, got %0d", want.blue, got.blue);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AA_FACTOR:       aa = cfg_data[AA_W-1:0];
          CFG_ITERATION_LIMIT: limit = cfg_data;
          CFG_MAX_ITERATIONS:  max_iter = cfg_data;
          CFG_PALETTE_ROTATE:  rotate = cfg_data;
          CFG_AUX_SHIFT:       shift = cfg_data[SHIFT_W-1:0];
          CFG_PALETTE_LENGTH:  plen = cfg_data[PLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_WRITE) begin
          if (in_entry_index < PALETTE_DEPTH) begin
            pal_red[in_entry_index] = in_entry_red;
            pal_green[in_entry_index] = in_entry_green;
            pal_blue[in_entry_index] = in_entry_blue;
          end
        end else begin
          if (in_iter_count < limit) begin
            slot = palette_slot(in_iter_count);
            acc_red = acc_red + 32'(pal_red[slot]);
            acc_green = acc_green + 32'(pal_green[slot]);
            acc_blue = acc_blue + 32'(pal_blue[slot]);
          end
          taken++;
          n = pixel_group();
          if (taken >= n) begin
            want.red = CH_W'(acc_red / n);
            want.green = CH_W'(acc_green / n);
            want.blue = CH_W'(acc_blue / n);
            pending_pixels.push_back(want);
            acc_red = '0;
            acc_green = '0;
            acc_blue = '0;
            taken = 0;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pixels_owed <= pending_pixels.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the escape count palette downsampler testbench: clock, reset,
// palette and sample stimulus, config phases, back-pressure and the verdict.
// Depends on ecpd_pkg, the block and ecpd_checker.
`timescale 1ns / 1ps

module tb_top import ecpd_pkg::*;;

  localparam int PALETTE_DEPTH = 4096;
  localparam int MAX_AA        = 8;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int QUIET_CYCLES  = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ITER_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_SAMPLE;
  logic [ITER_W-1:0]    in_iter_count = '0;
  logic [ENTRY_W-1:0]   in_entry_index = '0;
  logic [CH_W-1:0]      in_entry_red = '0;
  logic [CH_W-1:0]      in_entry_green = '0;
  logic [CH_W-1:0]      in_entry_blue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      out_pixel_red;
  logic [CH_W-1:0]      out_pixel_green;
  logic [CH_W-1:0]      out_pixel_blue;

  int                   mismatch_count;
  int                   pixels_owed;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   items_sent = 0;
  logic [ITER_W-1:0]    cur_limit = ITER_LIMIT_RST;
  logic [ITER_W-1:0]    cur_rotate = ROTATE_RST;
  logic [ITER_W-1:0]    cur_max = MAX_ITER_RST;
  logic [SHIFT_W-1:0]   cur_shift = AUX_SHIFT_RST;
  logic [PLEN_W-1:0]    cur_plen = PALETTE_LENGTH_RST;
  bit                   painted [PALETTE_DEPTH];

  escape_count_palette_downsampler #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_AA       (MAX_AA)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_iter_count  (in_iter_count),
    .in_entry_index (in_entry_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_red  (out_pixel_red),
    .out_pixel_green(out_pixel_green),
    .out_pixel_blue (out_pixel_blue)
  );

  ecpd_checker #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_AA       (MAX_AA)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_iter_count  (in_iter_count),
    .in_entry_index (in_entry_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_red  (out_pixel_red),
    .out_pixel_green(out_pixel_green),
    .out_pixel_blue (out_pixel_blue),
    .mismatch_count (mismatch_count),
    .pixels_owed    (pixels_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send(logic cmd, logic [ITER_W-1:0] iter, logic [ENTRY_W-1:0] idx,
                      logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_iter_count <= iter;
    in_entry_index <= idx;
    in_entry_red <= r;
    in_entry_green <= g;
    in_entry_blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic paint(logic [ENTRY_W-1:0] idx, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                       logic [CH_W-1:0] b);
    send(CMD_WRITE, $urandom, idx, r, g, b);
    if (idx < PALETTE_DEPTH) painted[idx] = 1'b1;
  endtask

  function automatic int unsigned slot_of(logic [ITER_W-1:0] count);
    logic [ITER_W:0]   total;
    logic [ITER_W-1:0] v;
    total = {1'b0, count} + {1'b0, cur_rotate};
    v = total[ITER_W-1:0];
    if (total[ITER_W] || v >= cur_max) v = (cur_max == '0) ? '0 : cur_max - 1'b1;
    v = v >> cur_shift;
    if (cur_plen == '0) return 0;
    v = v % ITER_W'(cur_plen);
    return v % PALETTE_DEPTH;
  endfunction

  // An entry not yet written is written just before the sample that reads it.
  task automatic sample(logic [ITER_W-1:0] iter);
    int unsigned slot;
    if (iter < cur_limit) begin
      slot = slot_of(iter);
      if (!painted[slot]) begin
        paint(ENTRY_W'(slot), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      end
    end
    send(CMD_SAMPLE, iter, ENTRY_W'($urandom), CH_W'($urandom), CH_W'($urandom),
         CH_W'($urandom));
  endtask

  // Waits until every pixel is out and the block has had time to finish
  // any item that yields no pixel.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [ITER_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [AA_W-1:0] aa, logic [ITER_W-1:0] lim,
                            logic [ITER_W-1:0] mx, logic [ITER_W-1:0] rot,
                            logic [SHIFT_W-1:0] sh, logic [PLEN_W-1:0] plen);
    put_reg(CFG_AA_FACTOR, ITER_W'(aa));
    put_reg(CFG_ITERATION_LIMIT, lim);
    put_reg(CFG_MAX_ITERATIONS, mx);
    put_reg(CFG_PALETTE_ROTATE, rot);
    put_reg(CFG_AUX_SHIFT, ITER_W'(sh));
    put_reg(CFG_PALETTE_LENGTH, ITER_W'(plen));
    cfg_valid <= 1'b0;
    cur_limit = lim;
    cur_rotate = rot;
    cur_max = mx;
    cur_shift = sh;
    cur_plen = plen;
  endtask

  task automatic set_pressure(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 73; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 73; end
      default: begin idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  function automatic logic [ITER_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1, 5000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ITER_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      3: return $urandom_range(0, 20000);
      4: return cur_limit - 1 + $urandom_range(0, 2);
      5: return ITER_W'(0) - cur_rotate - 2 + $urandom_range(0, 4);
      6: return '1 - $urandom_range(0, 3);
      7: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [AA_W-1:0]    aa;
    logic [PLEN_W-1:0]  plen;
    logic [SHIFT_W-1:0] sh;
    int                 group;
    int                 count;
    int                 base;
    int                 phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    paint(12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    paint(12'hFFF, 16'h0000, 16'h0000, 16'h0000);

    sample(32'd0);
    sample(32'hFFF);
    sample(32'hFFFF_FFFE);
    sample(32'hFFFF_FFFF);
    settle();

    set_config(4'd0, 32'd0, 32'd1, 32'd0, 5'd0, 13'd1);
    sample(32'd0);
    sample(32'hFFFF_FFFF);
    settle();

    set_config(4'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF0, 5'd0, 13'd8191);
    sample(32'h20);
    sample(32'd5);
    settle();

    set_config(4'd1, 32'hFFFF_FFFF, 32'h1000, 32'h8000_0000, 5'd0, 13'd4096);
    sample(32'h8000_0001);
    sample(32'h10);
    settle();

    set_config(4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 5'd31, 13'd0);
    sample(32'h8000_0000);
    sample(32'hFFFF_FFFF);
    settle();

    // The group size shrinks below what has already been gathered.
    set_config(4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 5'd0, 13'd8191);
    sample(32'd5000);
    settle();

    base = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      set_pressure(phase % 4);
      case ($urandom_range(0, 9))
        6: aa = 4'd0;
        7: aa = AA_W'($urandom_range(4, 7));
        8: aa = 4'd8;
        9: aa = AA_W'($urandom_range(9, 15));
        default: aa = AA_W'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 5))
        0: plen = 13'd0;
        1: plen = 13'd1;
        2: plen = 13'd4096;
        3: plen = 13'd8191;
        default: plen = PLEN_W'($urandom_range(1, 8191));
      endcase
      sh = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(0, 31));
      set_config(aa, pick_word(), pick_word(), pick_word(), sh, plen);
      group = (aa == 0) ? 1 : (aa > MAX_AA) ? MAX_AA * MAX_AA : aa * aa;
      count = group * $urandom_range(1, (group <= 9) ? 12 : 2);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, group);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          paint(ENTRY_W'($urandom), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        end
        sample(pick_count());
      end
      settle();
      phase++;
    end

    if (mismatch_count == 0 && pixels_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ecpd_pkg.sv
src/ecpd_rem_unit.sv
src/ecpd_palette.sv
src/ecpd_avg.sv
src/escape_count_palette_downsampler.sv
tb/ecpd_checker.sv
tb/tb_top.sv
